@@ rtl/lzgm_pkg.sv @@
`default_nettype none
package lzgm_pkg;

  localparam int HIST_SYMBOLS = 286;
  localparam int MIN_MATCH    = 3;
  localparam int LEN_CODES    = 29;

  localparam logic [8:0]  EOB_SYMBOL  = 9'd256;
  localparam logic [8:0]  FIRST_LCODE = 9'd257;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_DRAIN = 2'd1;
  localparam logic [1:0] OP_HREAD = 2'd2;

  localparam logic RK_TOKEN = 1'b0;
  localparam logic RK_HIST  = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic [8:0] symbol_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        is_match;
    logic [7:0]  literal_byte;
    logic [8:0]  match_length;
    logic [14:0] match_distance;
    logic [8:0]  symbol_code;
    logic        last_token;
    logic [31:0] hist_count;
  } out_item_t;

  // Shared controls that every compare cell sees in the same cycle.
  typedef struct packed {
    logic       shift;
    logic       s_vld;
    logic [7:0] s_byte;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_HINC_RD,
    ST_HINC_WR,
    ST_SHIFT,
    ST_HREAD,
    ST_LOAD
  } state_t;

  localparam logic [8:0] LEN_BASE [LEN_CODES] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };

  function automatic logic [8:0] length_code(input logic [8:0] len);
    logic [8:0] code;
    code = FIRST_LCODE;
    for (int i = 0; i < LEN_CODES; i++) begin
      if (len >= LEN_BASE[i]) begin
        code = FIRST_LCODE + 9'(i);
      end
    end
    return code;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lzgm_cell.sv @@
`default_nettype none
module lzgm_cell
  import lzgm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctl_t  ctl,
  input  wire logic       load,
  input  wire logic [7:0] load_byte,
  input  wire logic [7:0] shift_in,
  input  wire logic       en,
  input  wire logic       run_in,
  output logic      [7:0] lb,
  output logic            run
);

  always_ff @(posedge clk) begin
    if (load) begin
      lb <= load_byte;
    end else if (ctl.shift) begin
      lb <= shift_in;
    end
  end

  // A candidate survives this cell when every earlier byte matched and the
  // streamed byte equals the lookahead byte held here.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else begin
      run <= ctl.s_vld & run_in & en & (ctl.s_byte == lb);
    end
  end

endmodule
`default_nettype wire

@@ rtl/lz77_greedy_matcher.sv @@
// Greedy LZ77 tokenizer for deflate with a symbol histogram.
// Input channel (in_valid/in_ready/in_data): push a byte, drain one token, or
// read a histogram count. Output channel (out_valid/out_ready/out_data) gives
// at most one result per transaction: a token or a histogram count.
// A push that does not fill the lookahead is taken with no result.
// A token result is built in steps: the history (up to the window distance)
// and lookahead stream through a row of compare cells one byte per cycle from
// a single-port window memory, a read and a write state update the histogram,
// the lookahead row shifts out the consumed bytes one byte per cycle, and a
// load state loads the result. A histogram read result passes a read state and
// then the load state. in_ready rises with out_valid.
// After reset the histogram is swept clear (end-of-block set to one) with
// in_ready low. The finished result sits in an output register; if
// the receiver stalls, the block holds it and stops before loading the next.
`default_nettype none
module lz77_greedy_matcher
  import lzgm_pkg::*;
#(
  parameter int WINDOW_DISTANCE = 32767,
  parameter int MAX_MATCH       = 258
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int AW = $clog2(WINDOW_DISTANCE + MAX_MATCH);
  localparam int IW = AW + 1;
  localparam int FW = $clog2(WINDOW_DISTANCE + 1);
  localparam int CW = $clog2(MAX_MATCH + 1);
  localparam int RW = $clog2(MAX_MATCH);
  localparam int HW = $clog2(HIST_SYMBOLS);

  state_t state, state_next;

  logic [AW-1:0] wr;
  logic [FW-1:0] fill;
  logic [CW-1:0] count;
  logic [IW-1:0] rd_idx, s_idx, r_idx, n_len;
  logic [CW-1:0] best_len, shift_left;
  logic [IW-1:0] best_p;
  logic          drain_op, hist_ok;
  logic [HW-1:0] clr_idx;
  out_item_t     res;
  out_item_t     acc_res;
  out_item_t     res_out;

  logic [7:0] win_mem [2**AW];
  logic [7:0] s_byte;
  logic       s_vld;

  logic [31:0] hist_mem [HIST_SYMBOLS];
  logic [31:0] hist_q;

  logic          acc, push_acc, issue, load_out, h_we, h_re;
  logic [HW-1:0] h_wa, h_ra;
  logic [31:0]   h_wd;
  logic          tok_match;
  logic [CW-1:0] tok_used;
  logic [8:0]    tok_sym;
  logic          hit;

  cell_ctl_t            ctl;
  logic [7:0]           lb  [MAX_MATCH];
  logic [MAX_MATCH-1:0] run;

  // ---------------- compare cell row ----------------
  assign ctl.shift  = (state == ST_SHIFT);
  assign ctl.s_vld  = s_vld;
  assign ctl.s_byte = s_byte;

  for (genvar j = 0; j < MAX_MATCH; j++) begin : g_cell
    logic [7:0] nb;
    logic       rin;
    if (j + 1 < MAX_MATCH) begin : g_mid
      assign nb = lb[j+1];
    end else begin : g_end
      assign nb = 8'h00;
    end
    if (j == 0) begin : g_first
      assign rin = (s_idx < IW'(fill));
    end else begin : g_rest
      assign rin = run[j-1];
    end
    lzgm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .load      (push_acc && (count == CW'(j))),
      .load_byte (in_data.byte_value),
      .shift_in  (nb),
      .en        (count > CW'(j)),
      .run_in    (rin),
      .lb        (lb[j]),
      .run       (run[j])
    );
  end

  // ---------------- control ----------------
  assign n_len    = IW'(fill) + IW'(count) - IW'(1);
  assign acc      = in_valid && in_ready;
  assign push_acc = acc && (in_data.opcode == OP_PUSH);
  assign hit      = (best_len < CW'(MAX_MATCH)) && run[best_len[RW-1:0]];

  assign tok_match = (best_len >= CW'(MIN_MATCH));
  assign tok_used  = tok_match ? best_len : CW'(1);
  assign tok_sym   = tok_match ? length_code(9'(best_len)) : {1'b0, lb[0]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == HW'(HIST_SYMBOLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (in_data.opcode)
            OP_PUSH:  if (count == CW'(MAX_MATCH - 1)) state_next = ST_SEARCH;
            OP_DRAIN: if (count != '0) state_next = ST_SEARCH;
            OP_HREAD: state_next = ST_HREAD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH:  if (rd_idx == n_len + IW'(1)) state_next = ST_HINC_RD;
      ST_HINC_RD: state_next = ST_HINC_WR;
      ST_HINC_WR: state_next = ST_SHIFT;
      ST_SHIFT:   if (shift_left == CW'(1)) state_next = ST_LOAD;
      ST_HREAD:   state_next = ST_LOAD;
      ST_LOAD:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    issue    = (state == ST_SEARCH) && (rd_idx < n_len);
    load_out = (state == ST_LOAD) && (!out_valid || out_ready);
    h_re     = (state == ST_HREAD) || (state == ST_HINC_RD);
    h_ra     = (state == ST_HREAD) ? (hist_ok ? res.symbol_code[HW-1:0] : '0)
                                   : tok_sym[HW-1:0];
    h_we     = (state == ST_CLEAR) || (state == ST_HINC_WR);
    h_wa     = (state == ST_CLEAR) ? clr_idx : res.symbol_code[HW-1:0];
    if (state == ST_CLEAR) begin
      h_wd = (clr_idx == EOB_SYMBOL[HW-1:0]) ? 32'd1 : 32'd0;
    end else begin
      h_wd = (hist_q == COUNT_MAX) ? hist_q : hist_q + 32'd1;
    end
  end

  // A histogram read carries only its kind and the requested index until load.
  always_comb begin
    acc_res             = '0;
    acc_res.result_kind = RK_HIST;
    acc_res.symbol_code = in_data.symbol_index;
  end

  always_comb begin
    res_out = res;
    if (res.result_kind == RK_HIST) begin
      res_out.symbol_code = '0;
      res_out.hist_count  = hist_ok ? hist_q : 32'd0;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (push_acc) begin
      win_mem[wr + AW'(count)] <= in_data.byte_value;
    end
    if (issue) begin
      s_byte <= win_mem[wr - AW'(fill) + rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
    if (h_re) begin
      hist_q <= hist_mem[h_ra];
    end
  end

  // ---------------- state and datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      wr        <= '0;
      fill      <= '0;
      count     <= '0;
      clr_idx   <= '0;
      s_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      s_vld <= issue;
      if (state == ST_CLEAR) clr_idx <= clr_idx + HW'(1);
      if (push_acc) begin
        count <= count + CW'(1);
      end else if (state == ST_SHIFT) begin
        count <= count - CW'(1);
        wr    <= wr + AW'(1);
        if (fill < FW'(WINDOW_DISTANCE)) fill <= fill + FW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_idx <= rd_idx;
    r_idx <= s_idx;
    if (acc) begin
      rd_idx   <= '0;
      best_len <= '0;
      best_p   <= '0;
      drain_op <= (in_data.opcode == OP_DRAIN);
      res      <= acc_res;
      hist_ok  <= (in_data.symbol_index < 9'(HIST_SYMBOLS));
    end else if (state == ST_SEARCH) begin
      rd_idx <= rd_idx + IW'(1);
      // Lengths grow by at most one a cycle, so only the cell at best_len
      // can raise the best; the earliest candidate to reach it is farthest.
      if (hit) begin
        best_len <= best_len + CW'(1);
        best_p   <= r_idx - IW'(best_len);
      end
    end else if (state == ST_HINC_RD) begin
      res.result_kind    <= RK_TOKEN;
      res.is_match       <= tok_match;
      res.literal_byte   <= lb[0];
      res.match_length   <= tok_match ? 9'(best_len) : 9'd0;
      res.match_distance <= tok_match ? 15'(IW'(fill) - best_p) : 15'd0;
      res.symbol_code    <= tok_sym;
      res.last_token     <= drain_op && (count == tok_used);
      res.hist_count     <= '0;
      shift_left         <= tok_used;
    end else if (state == ST_SHIFT) begin
      shift_left <= shift_left - CW'(1);
    end
    if (load_out) begin
      out_data <= res_out;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_MATCH))
    else $error("lookahead count above capacity");

  a_best_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (best_len <= count))
    else $error("match longer than lookahead");

  a_match_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_match) |->
      (out_data.match_length >= 9'(MIN_MATCH) && out_data.match_distance != 15'd0
       && out_data.symbol_code >= FIRST_LCODE))
    else $error("malformed match token");

  a_hist_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == RK_HIST) |->
      (!out_data.is_match && out_data.match_length == 9'd0 && !out_data.last_token))
    else $error("histogram result carries token fields");
`endif

endmodule
`default_nettype wire
